### sv/mlfq_pkg.sv
// Package for the three-level feedback queue scheduler.
// Holds sizes, request/status codes, payload structs and the control/status
// structs shared by the controller, datapath and top level. No dependencies.
`timescale 1ns / 1ps

package mlfq_pkg;

    // Sizes
    localparam int QUEUE_DEPTH = 16;
    localparam int LEVELS      = 3;
    localparam int NSLOT       = LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(NSLOT);
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = $clog2(2 * QUEUE_DEPTH);
    localparam int LVL_W       = $clog2(LEVELS);
    localparam int CFG_IDX_W   = 2;

    // Request codes
    localparam logic [2:0] REQ_ADD      = 3'd0;
    localparam logic [2:0] REQ_DISPATCH = 3'd1;
    localparam logic [2:0] REQ_PREEMPT  = 3'd2;
    localparam logic [2:0] REQ_TICK     = 3'd3;
    localparam logic [2:0] REQ_BOOST    = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Job states on add
    localparam logic [1:0] JS_READY   = 2'd1;
    localparam logic [1:0] JS_RUNNING = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM2 = 2'd2;

    // Quantum reset values
    localparam logic [7:0] QUANTUM0_RST = 8'd2;
    localparam logic [7:0] QUANTUM1_RST = 8'd10;
    localparam logic [7:0] QUANTUM2_RST = 8'd20;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  job_id;
        logic [1:0]  job_state;
        logic [1:0]  job_level;
        logic        has_run;
        logic [15:0] ready_time;
        logic        running_present;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_job_id;
        logic [1:0]  out_level;
        logic [7:0]  out_quantum;
        logic [15:0] out_ready_time;
        logic        preempt;
    } rsp_t;

    // One queue slot
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] rt;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic disp_fin;
        logic tick_run;
        logic boost_run;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] req_type;
        logic       disp_hit;
        logic       scan_last;
        logic       boost_left;
    } dp_stat_t;

endpackage

### sv/mlfq_ctrl.sv
// Controller state machine of the feedback queue scheduler.
// Sequences request capture, execution, memory sweeps and the result strobe.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps

module mlfq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output mlfq_pkg::dp_cmd_t  cmd,
    input  mlfq_pkg::dp_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DISP,
        S_TICK,
        S_BOOST,
        S_DRAIN,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE, S_RESP:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                case (stat.req_type)
                    mlfq_pkg::REQ_DISPATCH: state_next = stat.disp_hit ? S_DISP : S_RESP;
                    mlfq_pkg::REQ_TICK:     state_next = S_TICK;
                    mlfq_pkg::REQ_BOOST:    state_next = S_BOOST;
                    default:                state_next = S_RESP;
                endcase
            end
            S_DISP:
            begin
                cmd.disp_fin = 1'b1;
                state_next   = S_RESP;
            end
            S_TICK:
            begin
                cmd.tick_run = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_BOOST:
            begin
                cmd.boost_run = 1'b1;
                if (!stat.boost_left)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_RESP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = !((state_next == S_IDLE) || (state_next == S_RESP));
        done_next = (state_next == S_RESP);
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

### sv/mlfq_datapath.sv
// Datapath of the feedback queue scheduler: slot memory, per-level FIFO
// pointers, quantum registers and the result register.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps

module mlfq_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mlfq_pkg::req_t                      req,
    input  logic                                cfg_we,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [7:0]                          cfg_data,
    input  mlfq_pkg::dp_cmd_t                   cmd,
    output mlfq_pkg::dp_stat_t                  stat,
    output mlfq_pkg::rsp_t                      rsp
);

    localparam int AW = mlfq_pkg::ADDR_W;
    localparam int PW = mlfq_pkg::PTR_W;
    localparam int CW = mlfq_pkg::CNT_W;
    localparam int LW = mlfq_pkg::LVL_W;
    localparam int SW = mlfq_pkg::SUM_W;
    localparam int LV = mlfq_pkg::LEVELS;
    localparam int QD = mlfq_pkg::QUEUE_DEPTH;

    // Slot memory
    mlfq_pkg::entry_t mem [mlfq_pkg::NSLOT];
    mlfq_pkg::entry_t rd_data_reg;

    logic [PW-1:0] head_reg  [LV];
    logic [PW-1:0] head_next [LV];
    logic [CW-1:0] count_reg  [LV];
    logic [CW-1:0] count_next [LV];
    logic [CW-1:0] total_reg, total_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic          wb_valid_reg, wb_valid_next;
    logic [AW-1:0] wb_addr_reg, wb_addr_next;
    logic          wb_inc_reg, wb_inc_next;
    logic [LW-1:0] disp_lvl_reg, disp_lvl_next;
    mlfq_pkg::req_t req_reg;
    mlfq_pkg::rsp_t rsp_reg, rsp_next;
    logic [7:0]    quantum0_reg, quantum1_reg, quantum2_reg;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    mlfq_pkg::entry_t mem_wdata;

    logic          full;
    logic [LW-1:0] add_lvl;
    logic          disp_hit;
    logic [LW-1:0] disp_lvl;
    logic          boost_left;
    logic [LW-1:0] boost_lvl;
    logic          pre_flag;

    function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] lvl,
                                                input logic [PW-1:0] ptr);
        slot_addr = AW'(lvl) * AW'(QD) + AW'(ptr);
    endfunction

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
        ptr_inc = (int'(ptr) == QD - 1) ? '0 : PW'(ptr + 1'b1);
    endfunction

    function automatic logic [PW-1:0] tail_of(input logic [PW-1:0] head,
                                              input logic [CW-1:0] cnt);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(cnt);
        if (int'(s) >= QD)
        begin
            s = s - SW'(QD);
        end
        tail_of = PW'(s);
    endfunction

    function automatic logic [7:0] quantum_of(input logic [LW-1:0] lvl,
                                              input logic [7:0] q0,
                                              input logic [7:0] q1,
                                              input logic [7:0] q2);
        if (int'(lvl) == 0)
        begin
            quantum_of = q0;
        end
        else if (int'(lvl) == 1)
        begin
            quantum_of = q1;
        end
        else
        begin
            quantum_of = q2;
        end
    endfunction

    // Decisions on the latched request and current occupancy
    always_comb
    begin
        logic [1:0] cur;
        full = (int'(total_reg) >= QD);
        cur  = (int'(req_reg.job_level) >= LV) ? 2'(LV - 1) : req_reg.job_level;
        if (req_reg.job_state == mlfq_pkg::JS_RUNNING)
        begin
            add_lvl = (int'(cur) < LV - 1) ? LW'(cur + 2'd1) : LW'(cur);
        end
        else if (req_reg.job_state == mlfq_pkg::JS_READY && req_reg.has_run)
        begin
            add_lvl = LW'(cur);
        end
        else
        begin
            add_lvl = '0;
        end

        // Highest nonempty level
        disp_hit = 1'b0;
        disp_lvl = '0;
        for (int l = LV - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                disp_hit = 1'b1;
                disp_lvl = LW'(l);
            end
        end

        // Highest nonempty level below level 0
        boost_left = 1'b0;
        boost_lvl  = '0;
        for (int l = LV - 1; l >= 1; l--)
        begin
            if (count_reg[l] != '0)
            begin
                boost_left = 1'b1;
                boost_lvl  = LW'(l);
            end
        end

        // Any job above the running job's level, or no running job at all
        pre_flag = !req_reg.running_present;
        for (int l = 0; l < LV; l++)
        begin
            if (l < int'(req_reg.job_level) && count_reg[l] != '0)
            begin
                pre_flag = 1'b1;
            end
        end
    end

    // Pointer, count and sweep updates
    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        scan_next     = scan_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = wb_addr_reg;
        wb_inc_next   = 1'b0;
        disp_lvl_next = disp_lvl_reg;
        rsp_next      = rsp_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        mem_we        = wb_valid_reg;
        mem_waddr     = wb_addr_reg;
        mem_wdata     = rd_data_reg;
        if (wb_inc_reg && rd_data_reg.rt != 16'hFFFF)
        begin
            mem_wdata.rt = rd_data_reg.rt + 16'd1;
        end

        if (cmd.capture)
        begin
            scan_next = '0;
        end

        if (cmd.exec)
        begin
            rsp_next = '0;
            case (req_reg.req_type)
                mlfq_pkg::REQ_ADD:
                begin
                    if (full)
                    begin
                        rsp_next.status = mlfq_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_we               = 1'b1;
                        mem_waddr            = slot_addr(add_lvl,
                                               tail_of(head_reg[add_lvl], count_reg[add_lvl]));
                        mem_wdata.id         = req_reg.job_id;
                        mem_wdata.rt         = req_reg.ready_time;
                        count_next[add_lvl]  = count_reg[add_lvl] + 1'b1;
                        total_next           = total_reg + 1'b1;
                        rsp_next.out_level   = 2'(add_lvl);
                        rsp_next.out_quantum = quantum_of(add_lvl, quantum0_reg,
                                                          quantum1_reg, quantum2_reg);
                    end
                end
                mlfq_pkg::REQ_DISPATCH:
                begin
                    if (disp_hit)
                    begin
                        rd_en                = 1'b1;
                        rd_addr              = slot_addr(disp_lvl, head_reg[disp_lvl]);
                        head_next[disp_lvl]  = ptr_inc(head_reg[disp_lvl]);
                        count_next[disp_lvl] = count_reg[disp_lvl] - 1'b1;
                        total_next           = total_reg - 1'b1;
                        disp_lvl_next        = disp_lvl;
                    end
                    else
                    begin
                        rsp_next.status = mlfq_pkg::ST_EMPTY;
                    end
                end
                mlfq_pkg::REQ_PREEMPT:
                begin
                    rsp_next.preempt = pre_flag;
                end
                default:
                begin
                    rsp_next.status = mlfq_pkg::ST_OK;
                end
            endcase
        end

        // Dispatched slot arrives from memory
        if (cmd.disp_fin)
        begin
            rsp_next.status         = mlfq_pkg::ST_OK;
            rsp_next.out_job_id     = rd_data_reg.id;
            rsp_next.out_level      = 2'(disp_lvl_reg);
            rsp_next.out_quantum    = quantum_of(disp_lvl_reg, quantum0_reg,
                                                 quantum1_reg, quantum2_reg);
            rsp_next.out_ready_time = rd_data_reg.rt;
            rsp_next.preempt        = 1'b0;
        end

        // Aging sweep: read one slot, write it back incremented next cycle
        if (cmd.tick_run)
        begin
            rd_en         = 1'b1;
            rd_addr       = scan_reg;
            scan_next     = scan_reg + 1'b1;
            wb_valid_next = 1'b1;
            wb_addr_next  = scan_reg;
            wb_inc_next   = 1'b1;
        end

        // Boost: move one job from a lower level to the level 0 tail
        if (cmd.boost_run && boost_left)
        begin
            rd_en                 = 1'b1;
            rd_addr               = slot_addr(boost_lvl, head_reg[boost_lvl]);
            head_next[boost_lvl]  = ptr_inc(head_reg[boost_lvl]);
            count_next[boost_lvl] = count_reg[boost_lvl] - 1'b1;
            count_next[0]         = count_reg[0] + 1'b1;
            wb_valid_next         = 1'b1;
            wb_addr_next          = slot_addr('0, tail_of(head_reg[0], count_reg[0]));
            wb_inc_next           = 1'b0;
        end
    end

    // Memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LV; l++)
            begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            total_reg    <= '0;
            wb_valid_reg <= 1'b0;
            quantum0_reg <= mlfq_pkg::QUANTUM0_RST;
            quantum1_reg <= mlfq_pkg::QUANTUM1_RST;
            quantum2_reg <= mlfq_pkg::QUANTUM2_RST;
        end
        else
        begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            wb_valid_reg <= wb_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    mlfq_pkg::CFG_QUANTUM0: quantum0_reg <= cfg_data;
                    mlfq_pkg::CFG_QUANTUM1: quantum1_reg <= cfg_data;
                    mlfq_pkg::CFG_QUANTUM2: quantum2_reg <= cfg_data;
                    default:                ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        scan_reg     <= scan_next;
        wb_addr_reg  <= wb_addr_next;
        wb_inc_reg   <= wb_inc_next;
        disp_lvl_reg <= disp_lvl_next;
        rsp_reg      <= rsp_next;
    end

    assign stat.req_type   = req_reg.req_type;
    assign stat.disp_hit   = disp_hit;
    assign stat.scan_last  = (int'(scan_reg) == mlfq_pkg::NSLOT - 1);
    assign stat.boost_left = boost_left;
    assign rsp             = rsp_reg;

endmodule

### sv/multilevel_feedback_queue_scheduler_top.sv
// Top level of the three-level feedback queue scheduler.
// Instantiates mlfq_ctrl and mlfq_datapath; depends on mlfq_pkg.
//
// Usage:
//   Requests: drive req and raise start; a transfer happens on a rising edge
//   with start high and busy low. Exactly one result per request appears on
//   rsp with done high for one cycle; the receiver cannot stall it.
//   Configuration: cfg_valid/cfg_ready write channel (cfg_ready is always
//   high), cfg_index selects quantum 0..2, other indexes are ignored.
//   Write it only while no request is in flight.
//   Sequence: add, preempt check and empty dispatch pass EXEC, then RESP
//   raises done; a dispatch that returns a job also passes DISP (one
//   registered memory read). Tick sweeps all 48 slots through the single
//   memory port in TICK; boost moves one job per cycle in BOOST; both
//   then pass DRAIN. busy is low in the done cycle, so a new request
//   can be accepted while done is high.
//   Reset: queues empty, quanta 2, 10, 20; no clearing pass is needed.
`timescale 1ns / 1ps

module multilevel_feedback_queue_scheduler_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  mlfq_pkg::req_t                   req,
    output logic                             done,
    output mlfq_pkg::rsp_t                   rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                       cfg_data
);

    mlfq_pkg::dp_cmd_t  cmd;
    mlfq_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    mlfq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    mlfq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp)
    );

endmodule

### sv/mlfq_checker.sv
// Port-level checker for the feedback queue scheduler, bound to the top.
// Depends on mlfq_pkg and multilevel_feedback_queue_scheduler_top.
`timescale 1ns / 1ps

module mlfq_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input mlfq_pkg::rsp_t rsp
);

    // A result never shows while a request is still executing
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // An accepted request occupies the block the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request not executing");

    // The strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // Status codes stay in the defined set
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == mlfq_pkg::ST_OK || rsp.status == mlfq_pkg::ST_FULL
                  || rsp.status == mlfq_pkg::ST_EMPTY))
        else $error("undefined status code");

endmodule

bind multilevel_feedback_queue_scheduler_top mlfq_checker u_mlfq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
